[hw/rtl/qtu_pkg.sv]
`timescale 1ns / 1ps

package qtu_pkg;

    // Field widths of the configuration registers and of the data words.
    localparam int STATE_COUNT_W  = 9;
    localparam int ACTION_COUNT_W = 5;
    localparam int COEF_W         = 16;
    localparam int VALUE_W        = 32;
    localparam int STATE_W        = 8;
    localparam int ACTION_W       = 4;

    // Datapath widths of the multiply-and-round unit.
    localparam int DELTA_W = 36;
    localparam int PROD_W  = DELTA_W + COEF_W + 1;
    localparam int FRAC_W  = 16;
    localparam int RES_W   = PROD_W - FRAC_W;
    localparam int SUM_W   = 38;

    // Width of the s * action_count + a address before it is fitted to the table.
    localparam int INDEX_W = STATE_W + ACTION_COUNT_W;

    localparam logic [STATE_COUNT_W-1:0]  STATE_COUNT_RST  = 9'd256;
    localparam logic [ACTION_COUNT_W-1:0] ACTION_COUNT_RST = 5'd16;
    localparam logic [COEF_W-1:0]         STEP_SIZE_RST    = 16'd6554;
    localparam logic [COEF_W-1:0]         DISCOUNT_RST     = 16'd64880;

    typedef enum logic [1:0] {
        REG_STATE_COUNT  = 2'd0,
        REG_ACTION_COUNT = 2'd1,
        REG_STEP_SIZE    = 2'd2,
        REG_DISCOUNT     = 2'd3
    } cfg_reg_t;

endpackage

[hw/rtl/qtu_ram.sv]
`timescale 1ns / 1ps

module qtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/qtu_mulrnd.sv]
`timescale 1ns / 1ps

// Unsigned Q0.16 coefficient times a signed value, rounded to nearest with
// ties toward plus infinity and scaled down by 2^16. The result is registered.
module qtu_mulrnd (
    input  logic                                   clk,
    input  logic [qtu_pkg::COEF_W-1:0]             coef,
    input  logic signed [qtu_pkg::DELTA_W-1:0]     operand,
    output logic signed [qtu_pkg::RES_W-1:0]       result
);

    localparam logic signed [qtu_pkg::PROD_W-1:0] HALF = qtu_pkg::PROD_W'(32768);

    logic signed [qtu_pkg::PROD_W-1:0] prod;
    logic signed [qtu_pkg::PROD_W-1:0] rounded;
    logic signed [qtu_pkg::RES_W-1:0]  result_reg;
    logic signed [qtu_pkg::RES_W-1:0]  result_next;

    always_comb
    begin
        prod        = $signed({1'b0, coef}) * operand;
        rounded     = prod + HALF;
        result_next = rounded[qtu_pkg::PROD_W-1:qtu_pkg::FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[hw/rtl/q_table_update_core.sv]
`timescale 1ns / 1ps

// Tabular Q-learning update engine.
// Input words arrive on s_axis: one experience (state, action, reward, next
// state) per word. For each word the block reads Q[s][a], scans Q[s'][b] over
// the actions in use for the maximum, and writes
//   Q[s][a] = old + alpha * (reward + gamma * max - old), saturated to 32 bits.
// The written value leaves on m_axis with status 0 in tuser; an index out of
// range gives a zero value, status 1 and no table write.
// Configuration registers are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while idle, which the block does not enforce.
// Processing: a word passes through ST_ADDR, ST_RD_OLD, ST_RD_MAX (one read per
// action on the single table read port) and ST_LAST, then the shared
// multiply-and-round unit is used twice (ST_MUL1, ST_ADD, ST_MUL2) before ST_FIN.
// A rejected word goes from ST_IDLE straight to ST_FIN. No new word is taken until
// the engine returns to idle; s_axis_tready is high only while the engine is idle.
// After reset the table is swept to zero, one entry per cycle, over all
// MAX_STATES * MAX_ACTIONS entries before s_axis_tready rises.
// A stalled m_axis holds its word; the next word may be accepted meanwhile and
// completes as soon as the output register is free.
module q_table_update_core #(
    parameter int MAX_STATES  = 256,
    parameter int MAX_ACTIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cur_state[7:0], taken_action[11:8], reward[43:12], following_state[51:44], zeros
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_value[31:0]
    output logic [31:0] m_axis_tdata,
    // status[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH  = MAX_STATES * MAX_ACTIONS;
    localparam int AW     = $clog2(DEPTH);
    localparam int SC_CAP = (MAX_STATES > 511) ? 511 : MAX_STATES;
    localparam int AC_CAP = (MAX_ACTIONS > 31) ? 31 : MAX_ACTIONS;

    localparam int SCW = qtu_pkg::STATE_COUNT_W;
    localparam int ACW = qtu_pkg::ACTION_COUNT_W;
    localparam int VW  = qtu_pkg::VALUE_W;
    localparam int DW  = qtu_pkg::DELTA_W;
    localparam int SW  = qtu_pkg::SUM_W;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_ADDR   = 10'b0000000100,
        ST_RD_OLD = 10'b0000001000,
        ST_RD_MAX = 10'b0000010000,
        ST_LAST   = 10'b0000100000,
        ST_MUL1   = 10'b0001000000,
        ST_ADD    = 10'b0010000000,
        ST_MUL2   = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SCW-1:0]            state_count_reg;
    logic [ACW-1:0]            action_count_reg;
    logic [15:0]               step_size_reg;
    logic [15:0]               discount_reg;

    logic [AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [ACW-1:0]            cnt_reg, cnt_next;
    logic                      bad_reg, bad_next;

    logic [7:0]                s_reg, s_next;
    logic [3:0]                a_reg, a_next;
    logic [7:0]                ns_reg, ns_next;
    logic signed [VW-1:0]      reward_reg, reward_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             base_reg, base_next;
    logic signed [VW-1:0]      old_reg, old_next;
    logic signed [VW-1:0]      best_reg, best_next;
    logic signed [DW-1:0]      delta_reg, delta_next;

    logic                      out_valid_reg, out_valid_next;
    logic [VW-1:0]             out_data_reg, out_data_next;
    logic                      out_user_reg, out_user_next;

    logic [SCW-1:0]            sc;
    logic [ACW-1:0]            ac;
    logic                      in_fire;
    logic                      in_bad;
    logic                      out_free;
    logic                      first_data;
    logic signed [VW-1:0]      rd_value;
    logic [qtu_pkg::INDEX_W-1:0] idx_wide;
    logic [qtu_pkg::INDEX_W-1:0] base_wide;
    logic signed [SW-1:0]      sum;
    logic signed [VW-1:0]      sat_value;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VW-1:0]             ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [VW-1:0]             ram_rdata;

    logic [15:0]               mul_coef;
    logic signed [DW-1:0]      mul_operand;
    logic signed [qtu_pkg::RES_W-1:0] mul_result;

    qtu_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qtu_mulrnd u_mulrnd (
        .clk     (clk),
        .coef    (mul_coef),
        .operand (mul_operand),
        .result  (mul_result)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg  <= qtu_pkg::STATE_COUNT_RST;
            action_count_reg <= qtu_pkg::ACTION_COUNT_RST;
            step_size_reg    <= qtu_pkg::STEP_SIZE_RST;
            discount_reg     <= qtu_pkg::DISCOUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (qtu_pkg::cfg_reg_t'(cfg_index))
                qtu_pkg::REG_STATE_COUNT:  state_count_reg  <= cfg_data[SCW-1:0];
                qtu_pkg::REG_ACTION_COUNT: action_count_reg <= cfg_data[ACW-1:0];
                qtu_pkg::REG_STEP_SIZE:    step_size_reg    <= cfg_data;
                qtu_pkg::REG_DISCOUNT:     discount_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        sc = (state_count_reg > SCW'(SC_CAP)) ? SCW'(SC_CAP) : state_count_reg;
        ac = (action_count_reg > ACW'(AC_CAP)) ? ACW'(AC_CAP) : action_count_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_bad        = ({1'b0, s_axis_tdata[7:0]} >= sc)
                        || ({1'b0, s_axis_tdata[51:44]} >= sc)
                        || ({1'b0, s_axis_tdata[11:8]} >= ac);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign rd_value      = $signed(ram_rdata);

    always_comb
    begin
        idx_wide  = qtu_pkg::INDEX_W'(s_reg) * qtu_pkg::INDEX_W'(ac)
                  + qtu_pkg::INDEX_W'(a_reg);
        base_wide = qtu_pkg::INDEX_W'(ns_reg) * qtu_pkg::INDEX_W'(ac);
        sum       = SW'(old_reg) + SW'(mul_result);
        if (sum > SW'(32'sh7FFFFFFF))
        begin
            sat_value = 32'sh7FFFFFFF;
        end
        else if (sum < -SW'(64'sh80000000))
        begin
            sat_value = 32'sh80000000;
        end
        else
        begin
            sat_value = sum[VW-1:0];
        end
    end

    // The first multiply scales the maximum by gamma, the second scales the
    // difference by alpha. The alpha product is kept selected while the
    // result waits for the output register, so the step stays valid.
    always_comb
    begin
        if (state_reg == ST_MUL2 || state_reg == ST_FIN)
        begin
            mul_coef    = step_size_reg;
            mul_operand = delta_reg;
        end
        else
        begin
            mul_coef    = discount_reg;
            mul_operand = DW'(best_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        s_next         = s_reg;
        a_next         = a_reg;
        ns_next        = ns_reg;
        reward_next    = reward_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        old_next       = old_reg;
        best_next      = best_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = sat_value;
        ram_raddr      = idx_reg;
        first_data     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    s_next      = s_axis_tdata[7:0];
                    a_next      = s_axis_tdata[11:8];
                    reward_next = $signed(s_axis_tdata[43:12]);
                    ns_next     = s_axis_tdata[51:44];
                    bad_next    = in_bad;
                    state_next  = in_bad ? ST_FIN : ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                idx_next   = AW'(idx_wide);
                base_next  = AW'(base_wide);
                state_next = ST_RD_OLD;
            end
            ST_RD_OLD:
            begin
                cnt_next   = '0;
                state_next = ST_RD_MAX;
            end
            ST_RD_MAX:
            begin
                // Read data lags the address by the RAM's output register: at count zero it is
                // the old value, afterwards entry count - 1 of the next state.
                ram_raddr = base_reg + AW'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    old_next = rd_value;
                end
                else
                begin
                    first_data = (cnt_reg == ACW'(1));
                    if (first_data || rd_value > best_reg)
                    begin
                        best_next = rd_value;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ac - 1'b1)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                first_data = (ac == ACW'(1));
                if (first_data || rd_value > best_reg)
                begin
                    best_next = rd_value;
                end
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                delta_next = DW'(reward_reg) + DW'(mul_result) - DW'(old_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = bad_reg ? '0 : sat_value;
                    out_user_next  = bad_reg;
                    ram_we         = !bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        a_reg        <= a_next;
        ns_reg       <= ns_next;
        reward_reg   <= reward_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        old_reg      <= old_next;
        best_reg     <= best_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
